// ===== rtl/bsf_pkg.sv =====
package bsf_pkg;

  localparam int MAX_ITEMS  = 64;
  localparam int VALUE_BITS = 16;
  localparam int IDX_W      = $clog2(MAX_ITEMS);
  localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
  localparam int BKT_W      = IDX_W;
  localparam int PROD_W     = CNT_W + VALUE_BITS;

  typedef enum logic [2:0] {
    S_LOAD,
    S_BRD,
    S_BMUL,
    S_BWR,
    S_SCAN
  } state_t;

  typedef struct packed {
    logic                  item_we;
    logic [IDX_W-1:0]      item_waddr;
    logic [VALUE_BITS-1:0] item_wdata;
    logic                  bkt_we;
    logic [IDX_W-1:0]      bkt_waddr;
    logic [BKT_W-1:0]      bkt_wdata;
    logic [IDX_W-1:0]      raddr;
  } store_req_t;

endpackage

// ===== rtl/bucket_sort_fraction_top.sv =====
// Bucket sort of a run of unsigned 16-bit fractions in [0,1).
// Input: an item (value, last) transfers at a rising edge where start is high
// and busy is low. Items are stored one per cycle; up to 64 items are kept and
// later ones are dropped, which sets overflow on every result of that run.
// The item with last high closes the run (it is stored if there is room).
// After closing, busy stays high while the block works: each kept item is read,
// multiplied and assigned (S_BRD, S_BMUL, S_BWR) to bucket floor(n*value/65536),
// where n is the kept count. Then each bucket is scanned in order; one scan of
// the store yields either the smallest remaining item of the current bucket
// or moves to the next bucket. There are n results and at most n - 1 bucket
// advances; a single read address of the store is walked by one compare unit.
// Output: each result appears on sorted_value, last_out and overflow for one
// cycle with strobe high; the receiver cannot stall. Results come in
// ascending order, last_out high on the final one; busy drops in that cycle.
// Reset (rst, synchronous) empties the run and returns to accepting items.
module bucket_sort_fraction_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] value,
  input  logic        last,
  output logic        strobe,
  output logic [15:0] sorted_value,
  output logic        last_out,
  output logic        overflow
);

  bsf_pkg::store_req_t            req;
  logic [bsf_pkg::VALUE_BITS-1:0] item_rdata;
  logic [bsf_pkg::BKT_W-1:0]      bkt_rdata;

  bsf_store u_store (
    .clk        (clk),
    .req        (req),
    .item_rdata (item_rdata),
    .bkt_rdata  (bkt_rdata)
  );

  bsf_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .value        (value),
    .last         (last),
    .strobe       (strobe),
    .sorted_value (sorted_value),
    .last_out     (last_out),
    .overflow     (overflow),
    .req          (req),
    .item_rdata   (item_rdata),
    .bkt_rdata    (bkt_rdata)
  );

endmodule

// ===== rtl/bsf_store.sv =====
module bsf_store (
  input  logic                           clk,
  input  bsf_pkg::store_req_t            req,
  output logic [bsf_pkg::VALUE_BITS-1:0] item_rdata,
  output logic [bsf_pkg::BKT_W-1:0]      bkt_rdata
);

  logic [bsf_pkg::VALUE_BITS-1:0] item_mem [bsf_pkg::MAX_ITEMS];
  logic [bsf_pkg::BKT_W-1:0]      bkt_mem  [bsf_pkg::MAX_ITEMS];

  always_ff @(posedge clk) begin
    if (req.item_we) begin
      item_mem[req.item_waddr] <= req.item_wdata;
    end
    item_rdata <= item_mem[req.raddr];
  end

  always_ff @(posedge clk) begin
    if (req.bkt_we) begin
      bkt_mem[req.bkt_waddr] <= req.bkt_wdata;
    end
    bkt_rdata <= bkt_mem[req.raddr];
  end

endmodule

// ===== rtl/bsf_seq.sv =====
module bsf_seq (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [bsf_pkg::VALUE_BITS-1:0] value,
  input  logic                           last,
  output logic                           strobe,
  output logic [bsf_pkg::VALUE_BITS-1:0] sorted_value,
  output logic                           last_out,
  output logic                           overflow,
  output bsf_pkg::store_req_t            req,
  input  logic [bsf_pkg::VALUE_BITS-1:0] item_rdata,
  input  logic [bsf_pkg::BKT_W-1:0]      bkt_rdata
);

  bsf_pkg::state_t state, state_next;

  logic [bsf_pkg::CNT_W-1:0]      count;
  logic                           dropped;
  logic [bsf_pkg::IDX_W-1:0]      idx;
  logic [bsf_pkg::PROD_W-1:0]     prod;
  logic [bsf_pkg::CNT_W-1:0]      scan_addr;
  logic                           p_valid;
  logic [bsf_pkg::IDX_W-1:0]      p_idx;
  logic [bsf_pkg::BKT_W-1:0]      bucket;
  logic                           found;
  logic [bsf_pkg::VALUE_BITS-1:0] best;
  logic [bsf_pkg::IDX_W-1:0]      best_idx;
  logic [bsf_pkg::CNT_W-1:0]      emit_cnt;
  logic [bsf_pkg::MAX_ITEMS-1:0]  taken;

  logic                           accept;
  logic                           has_room;
  logic                           idx_end;
  logic                           scan_end;
  logic                           final_pick;
  logic                           hit;
  logic [bsf_pkg::CNT_W-1:0]      bkt_raw;
  logic [bsf_pkg::CNT_W-1:0]      n_minus1;

  assign busy       = (state != bsf_pkg::S_LOAD);
  assign accept     = start && !busy;
  assign has_room   = (count < bsf_pkg::CNT_W'(bsf_pkg::MAX_ITEMS));
  assign n_minus1   = count - bsf_pkg::CNT_W'(1);
  assign idx_end    = ({1'b0, idx} == n_minus1);
  assign scan_end   = (scan_addr == count) && !p_valid;
  assign final_pick = found && (emit_cnt == n_minus1);
  assign bkt_raw    = prod[bsf_pkg::PROD_W-1:bsf_pkg::VALUE_BITS];
  assign hit        = p_valid && !taken[p_idx] && (bkt_rdata == bucket) &&
                      (!found || (item_rdata < best));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsf_pkg::S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    req.item_we    = 1'b0;
    req.item_waddr = count[bsf_pkg::IDX_W-1:0];
    req.item_wdata = value;
    req.bkt_we     = 1'b0;
    req.bkt_waddr  = idx;
    req.bkt_wdata  = (bkt_raw > n_minus1) ? n_minus1[bsf_pkg::BKT_W-1:0]
                                          : bkt_raw[bsf_pkg::BKT_W-1:0];
    req.raddr      = idx;
    unique case (state)
      bsf_pkg::S_LOAD: begin
        req.item_we = accept && has_room;
        if (accept && last) begin
          state_next = bsf_pkg::S_BRD;
        end
      end
      bsf_pkg::S_BRD: begin
        state_next = bsf_pkg::S_BMUL;
      end
      bsf_pkg::S_BMUL: begin
        state_next = bsf_pkg::S_BWR;
      end
      bsf_pkg::S_BWR: begin
        req.bkt_we = 1'b1;
        state_next = idx_end ? bsf_pkg::S_SCAN : bsf_pkg::S_BRD;
      end
      bsf_pkg::S_SCAN: begin
        req.raddr = scan_addr[bsf_pkg::IDX_W-1:0];
        if (scan_end && final_pick) begin
          state_next = bsf_pkg::S_LOAD;
        end
      end
      default: begin
        state_next = bsf_pkg::S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      dropped  <= 1'b0;
      idx      <= '0;
      scan_addr <= '0;
      p_valid  <= 1'b0;
      bucket   <= '0;
      found    <= 1'b0;
      emit_cnt <= '0;
      taken    <= '0;
      strobe   <= 1'b0;
      last_out <= 1'b0;
      overflow <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        bsf_pkg::S_LOAD: begin
          if (accept) begin
            if (has_room) begin
              count <= count + bsf_pkg::CNT_W'(1);
            end else begin
              dropped <= 1'b1;
            end
            idx <= '0;
          end
        end
        bsf_pkg::S_BRD: begin
        end
        bsf_pkg::S_BMUL: begin
          prod <= bsf_pkg::PROD_W'(count) * bsf_pkg::PROD_W'(item_rdata);
        end
        bsf_pkg::S_BWR: begin
          idx <= idx + bsf_pkg::IDX_W'(1);
          if (idx_end) begin
            scan_addr <= '0;
            p_valid   <= 1'b0;
            bucket    <= '0;
            found     <= 1'b0;
            emit_cnt  <= '0;
            taken     <= '0;
          end
        end
        bsf_pkg::S_SCAN: begin
          if (scan_addr != count) begin
            p_idx     <= scan_addr[bsf_pkg::IDX_W-1:0];
            p_valid   <= 1'b1;
            scan_addr <= scan_addr + bsf_pkg::CNT_W'(1);
          end else begin
            p_valid <= 1'b0;
          end
          if (hit) begin
            found    <= 1'b1;
            best     <= item_rdata;
            best_idx <= p_idx;
          end
          if (scan_end) begin
            scan_addr <= '0;
            found     <= 1'b0;
            if (found) begin
              strobe          <= 1'b1;
              sorted_value    <= best;
              last_out        <= final_pick;
              overflow        <= dropped;
              taken[best_idx] <= 1'b1;
              emit_cnt        <= emit_cnt + bsf_pkg::CNT_W'(1);
              if (final_pick) begin
                count   <= '0;
                dropped <= 1'b0;
              end
            end else begin
              bucket <= bucket + bsf_pkg::BKT_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= bsf_pkg::CNT_W'(bsf_pkg::MAX_ITEMS))
    else $error("item count exceeds store capacity");

  a_strobe_from_scan: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(state) == bsf_pkg::S_SCAN)
    else $error("result transfer outside of the scan phase");

  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    state == bsf_pkg::S_SCAN |-> emit_cnt < count)
    else $error("more results than kept items");

  a_bucket_range: assert property (@(posedge clk) disable iff (rst)
    req.bkt_we |-> {1'b0, req.bkt_wdata} < count)
    else $error("bucket index out of range");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (strobe && last_out) |-> state == bsf_pkg::S_LOAD && count == '0)
    else $error("run not closed after final result");

endmodule
